// ===== sv/hidbk_pkg.sv =====
// ----------------------------------------------------------------------------
// hidbk_pkg
// Types, constants and translation tables for the HID boot keyboard
// report key event decoder.
// ----------------------------------------------------------------------------
package hidbk_pkg;

	typedef logic [7:0] usage_t;

	localparam int KEY_SLOTS = 6;
	localparam int MOD_BITS  = 8;
	localparam int EV_COUNT  = MOD_BITS + 2 * KEY_SLOTS;
	localparam int EV_W      = $clog2(EV_COUNT);
	localparam int KEY_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

	localparam usage_t DEAD_CODE      = 8'hFF;
	localparam usage_t MIN_KEY_USAGE  = 8'h04;
	localparam usage_t MAX_KEY_USAGE  = 8'h75;
	localparam usage_t MOD_USAGE_BASE = 8'hE0;
	localparam usage_t ROLLOVER_MARK  = 8'h01;

	localparam usage_t KEY_TABLE [0:117] = '{
		8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'h00, 8'h0b, 8'h08, 8'h02, 8'h0e, 8'h03, 8'h05, 8'h04, 8'h22, 8'h26, 8'h28, 8'h25,
		8'h2e, 8'h2d, 8'h1f, 8'h23, 8'h0c, 8'h0f, 8'h01, 8'h11, 8'h20, 8'h09, 8'h0d, 8'h07,
		8'h10, 8'h06, 8'h12, 8'h13, 8'h14, 8'h15, 8'h17, 8'h16, 8'h1a, 8'h1c, 8'h19, 8'h1d,
		8'h24, 8'h35, 8'h33, 8'h30, 8'h31, 8'h1b, 8'h18, 8'h21, 8'h1e, 8'h2a, 8'h2a, 8'h29,
		8'h27, 8'h32, 8'h2b, 8'h2f, 8'h2c, 8'h39, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h60, 8'h61,
		8'h62, 8'h64, 8'h65, 8'h6d, 8'h67, 8'h6f, 8'h69, 8'h6b, 8'h71, 8'h72, 8'h73, 8'h74,
		8'h75, 8'h77, 8'h79, 8'h7c, 8'h7b, 8'h7d, 8'h7e, 8'h47, 8'h4b, 8'h43, 8'h4e, 8'h45,
		8'h4c, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5b, 8'h5c, 8'h52, 8'h41,
		8'h0a, 8'h6e, 8'h7f, 8'h51, 8'h69, 8'h6b, 8'h71, 8'h6a, 8'h40, 8'h4f, 8'h50, 8'h5a,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h72
	};

	localparam logic [6:0] MOD_TABLE [0:7] = '{
		7'h3b, 7'h38, 7'h3a, 7'h37, 7'h3e, 7'h3c, 7'h3d, 7'h36
	};

	// Raw table entry for a key usage; anything past the table is dead.
	function automatic usage_t key_code(input usage_t usage);
		usage_t code;
		code = DEAD_CODE;
		if (usage <= MAX_KEY_USAGE) begin
			code = KEY_TABLE[usage[6:0]];
		end
		return code;
	endfunction

	function automatic logic key_in_range(input usage_t usage);
		return (usage >= MIN_KEY_USAGE) && (usage <= MAX_KEY_USAGE);
	endfunction

endpackage

// ===== sv/hid_boot_report_key_events_core.sv =====
// ----------------------------------------------------------------------------
// hid_boot_report_key_events_core
// Compares each boot keyboard report with the previous one and emits key
// events: modifier changes, then releases, then presses.
// ----------------------------------------------------------------------------
// An accepted report is held in the input register, where it is compared
// with the stored report and turned into a mask of up to 20 pending events;
// the emitter then delivers one event per cycle through the output register
// while the output is not stalled, lowest pending event first. The next report
// is taken into the input register while those events drain. Rollover and
// no-change reports are loaded with no result.
module hid_boot_report_key_events_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] modifier_bits,
	input  logic [7:0] key_slot_0,
	input  logic [7:0] key_slot_1,
	input  logic [7:0] key_slot_2,
	input  logic [7:0] key_slot_3,
	input  logic [7:0] key_slot_4,
	input  logic [7:0] key_slot_5,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] usage_code,
	output logic       pressed,
	output logic [6:0] translated_code,
	output logic       translated_valid,
	output logic       last_event
);

	localparam int KS  = hidbk_pkg::KEY_SLOTS;
	localparam int MB  = hidbk_pkg::MOD_BITS;
	localparam int EVC = hidbk_pkg::EV_COUNT;
	localparam int EW  = hidbk_pkg::EV_W;
	localparam int KW  = hidbk_pkg::KEY_W;

	// input register
	logic                   valid_s1;
	logic [7:0]             mods_s1;
	hidbk_pkg::usage_t      keys_s1 [KS];

	// stored report and pending events
	logic [7:0]             prev_mods_q;
	hidbk_pkg::usage_t      prev_keys_q [KS];
	hidbk_pkg::usage_t      old_keys_q [KS];
	logic [EVC-1:0]         pend_q;

	// output register
	logic                   out_valid_q;
	hidbk_pkg::usage_t      out_usage_q;
	logic                   out_pressed_q;
	logic [6:0]             out_code_q;
	logic                   out_tvalid_q;
	logic                   out_last_q;

	logic                   load;
	logic                   advance;
	logic [EVC-1:0]         mask;
	logic                   in_new [KS];
	logic                   in_old [KS];
	logic [EW-1:0]          sel;
	logic [EW-1:0]          rel_off;
	logic [EW-1:0]          prs_off;
	logic [EVC-1:0]         rest;
	hidbk_pkg::usage_t      ev_usage;
	hidbk_pkg::usage_t      ev_raw;
	logic                   ev_pressed;
	logic [6:0]             ev_code;
	logic                   ev_tvalid;

	assign load     = valid_s1 && (pend_q == '0);
	assign in_stall = valid_s1 && (pend_q != '0);
	assign advance  = !out_valid_q || !out_stall;

	// compare the held report with the stored one
	always_comb begin
		for (int i = 0; i < KS; i++) begin
			in_new[i] = 1'b0;
			in_old[i] = 1'b0;
			for (int j = 0; j < KS; j++) begin
				if (keys_s1[j] == prev_keys_q[i]) in_new[i] = 1'b1;
				if (prev_keys_q[j] == keys_s1[i]) in_old[i] = 1'b1;
			end
		end
		mask = '0;
		if (keys_s1[0] != hidbk_pkg::ROLLOVER_MARK) begin
			mask[MB-1:0] = mods_s1 ^ prev_mods_q;
			for (int i = 0; i < KS; i++) begin
				mask[MB + i] = !in_new[i] && hidbk_pkg::key_in_range(prev_keys_q[i]);
				mask[MB + KS + i] = !in_old[i] && hidbk_pkg::key_in_range(keys_s1[i]);
			end
		end
	end

	// pick the lowest pending event
	always_comb begin
		sel = '0;
		for (int j = EVC - 1; j >= 0; j--) begin
			if (pend_q[j]) sel = EW'(j);
		end
		rest    = pend_q & ~({{(EVC-1){1'b0}}, 1'b1} << sel);
		rel_off = sel - EW'(MB);
		prs_off = sel - EW'(MB + KS);
	end

	always_comb begin
		ev_usage   = '0;
		ev_pressed = 1'b0;
		ev_code    = '0;
		ev_tvalid  = 1'b1;
		ev_raw     = hidbk_pkg::DEAD_CODE;
		if (sel < EW'(MB)) begin
			ev_usage   = hidbk_pkg::MOD_USAGE_BASE | {5'b0, sel[2:0]};
			ev_pressed = prev_mods_q[sel[2:0]];
			ev_code    = hidbk_pkg::MOD_TABLE[sel[2:0]];
		end else begin
			if (sel < EW'(MB + KS)) begin
				ev_usage   = old_keys_q[rel_off[KW-1:0]];
				ev_pressed = 1'b0;
			end else begin
				ev_usage   = prev_keys_q[prs_off[KW-1:0]];
				ev_pressed = 1'b1;
			end
			ev_raw    = hidbk_pkg::key_code(ev_usage);
			ev_tvalid = (ev_raw != hidbk_pkg::DEAD_CODE);
			ev_code   = ev_tvalid ? ev_raw[6:0] : 7'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			prev_mods_q <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < KS; i++) prev_keys_q[i] <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (load) begin
				// store the report, keep the old keys for the releases
				pend_q      <= mask;
				prev_mods_q <= mods_s1;
				for (int i = 0; i < KS; i++) prev_keys_q[i] <= keys_s1[i];
			end else if (advance && (pend_q != '0)) begin
				pend_q <= rest;
			end
			if (advance) begin
				out_valid_q <= (pend_q != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			mods_s1    <= modifier_bits;
			keys_s1[0] <= key_slot_0;
			keys_s1[1] <= key_slot_1;
			keys_s1[2] <= key_slot_2;
			keys_s1[3] <= key_slot_3;
			keys_s1[4] <= key_slot_4;
			keys_s1[5] <= key_slot_5;
		end
		if (load) begin
			for (int i = 0; i < KS; i++) old_keys_q[i] <= prev_keys_q[i];
		end
		if (advance && (pend_q != '0)) begin
			out_usage_q   <= ev_usage;
			out_pressed_q <= ev_pressed;
			out_code_q    <= ev_code;
			out_tvalid_q  <= ev_tvalid;
			out_last_q    <= (rest == '0);
		end
	end

	assign out_valid        = out_valid_q;
	assign usage_code       = out_usage_q;
	assign pressed          = out_pressed_q;
	assign translated_code  = out_code_q;
	assign translated_valid = out_tvalid_q;
	assign last_event       = out_last_q;

	// an event that is not the last leaves work behind, so no report can load
	a_pending_after_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (pend_q != '0))
		else $error("event without last flag but nothing pending");

	a_rollover_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (keys_s1[0] == hidbk_pkg::ROLLOVER_MARK)) |=> (pend_q == '0))
		else $error("rollover report produced events");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_usage_q < hidbk_pkg::MOD_USAGE_BASE)) |->
		hidbk_pkg::key_in_range(out_usage_q))
		else $error("key event outside usage range");

	a_mod_translated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_usage_q >= hidbk_pkg::MOD_USAGE_BASE)) |-> out_tvalid_q)
		else $error("modifier event without translation");

endmodule
